// ===== src/rtdwc_pkg.sv =====
// ----------------------------------------------------------------------------
// rtdwc_pkg: shared types and constants of the waypoint controller
// Payload words, sequencer states, fixed-point constants, arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package rtdwc_pkg;

    localparam int RTDWC_CORDIC_STEPS = 16;

    localparam logic [14:0] FULL_TURN = 15'd23040;
    localparam logic [14:0] HALF_TURN = 15'd11520;

    // fine angle units: 1/16384 degree
    localparam logic signed [23:0] FINE_180 = 24'sd2949120;
    localparam logic signed [23:0] FINE_360 = 24'sd5898240;

    // squared distance bands, 1/1024 m units squared
    localparam logic [32:0] BAND_FAST_SQ = 33'd37748736;
    localparam logic [32:0] BAND_MID_SQ  = 33'd4194304;
    localparam logic [32:0] BAND_SLOW_SQ = 33'd262144;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_ROTATE = 2'd1;
    localparam logic [1:0] PH_HOLD   = 2'd2;
    localparam logic [1:0] PH_DRIVE  = 2'd3;

    localparam logic [1:0] TURN_NONE = 2'd0;
    localparam logic [1:0] TURN_POS  = 2'd1;
    localparam logic [1:0] TURN_NEG  = 2'd3;

    localparam logic [2:0] REG_HOLD_TICKS  = 3'd0;
    localparam logic [2:0] REG_ARRIVE_DIST = 3'd1;
    localparam logic [2:0] REG_ALIGN_TOL   = 3'd2;
    localparam logic [2:0] REG_COARSE_BAND = 3'd3;
    localparam logic [2:0] REG_FINE_BAND   = 3'd4;
    localparam logic [2:0] REG_DEV_LIMIT   = 3'd5;

    typedef struct packed {
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [14:0] heading;
        logic [15:0] goal_x;
        logic [15:0] goal_y;
        logic        new_goal;
    } t_in_word;

    typedef struct packed {
        logic [3:0]        linear_cmd;
        logic signed [7:0] angular_cmd;
        logic [1:0]        phase_out;
        logic              arrived;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_WAIT,
        ST_EVAL
    } t_state;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_RUN,
        CS_NORM,
        CS_ROUND,
        CS_DONE
    } t_cor_state;

    // atan(2^-i) in 1/16384 degree
    function automatic logic signed [23:0] atan_fine(input logic [4:0] idx);
        logic signed [23:0] v;
        case (idx)
            5'd0:  v = 24'sd737280;
            5'd1:  v = 24'sd435242;
            5'd2:  v = 24'sd229970;
            5'd3:  v = 24'sd116736;
            5'd4:  v = 24'sd58595;
            5'd5:  v = 24'sd29326;
            5'd6:  v = 24'sd14667;
            5'd7:  v = 24'sd7334;
            5'd8:  v = 24'sd3667;
            5'd9:  v = 24'sd1833;
            5'd10: v = 24'sd917;
            5'd11: v = 24'sd458;
            5'd12: v = 24'sd229;
            5'd13: v = 24'sd115;
            5'd14: v = 24'sd57;
            5'd15: v = 24'sd29;
            5'd16: v = 24'sd14;
            5'd17: v = 24'sd7;
            5'd18: v = 24'sd4;
            5'd19: v = 24'sd2;
            5'd20: v = 24'sd1;
            default: v = 24'sd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== src/rtdwc_cordic.sv =====
// ----------------------------------------------------------------------------
// rtdwc_cordic: iterative CORDIC bearing unit
// One vectoring micro-rotation per cycle, then wrap and round to 1/64 degree.
// ----------------------------------------------------------------------------
`default_nettype none

module rtdwc_cordic
    import rtdwc_pkg::*;
#(
    parameter int CORDIC_STEPS = RTDWC_CORDIC_STEPS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [16:0] i_dx,
    input  wire logic signed [16:0] i_dy,
    output logic                    o_done,
    output logic [14:0]             o_bearing
);

    localparam int SW = $clog2(CORDIC_STEPS + 1);
    localparam logic [SW-1:0] LAST_STEP = SW'(CORDIC_STEPS - 1);

    t_cor_state r_state, n_state;
    logic [SW-1:0]      r_step;
    logic signed [27:0] r_x, r_y;
    logic signed [23:0] r_z;
    logic [14:0]        r_bearing;

    logic signed [16:0] ax, ay;
    logic signed [27:0] xs, ys;
    logic signed [23:0] at;
    logic [15:0]        rnd;

    assign ax  = i_dx[16] ? -i_dx : i_dx;
    assign ay  = i_dx[16] ? -i_dy : i_dy;
    assign xs  = r_x >>> r_step;
    assign ys  = r_y >>> r_step;
    assign at  = atan_fine(5'(r_step));
    assign rnd = 16'((r_z + 24'sd128) >>> 8);

    always_comb begin
        n_state = r_state;
        case (r_state)
            CS_IDLE:  n_state = CS_IDLE;
            CS_RUN:   if (r_step == LAST_STEP) n_state = CS_NORM;
            CS_NORM:  n_state = CS_ROUND;
            CS_ROUND: n_state = CS_DONE;
            CS_DONE:  n_state = CS_DONE;
            default:  n_state = CS_IDLE;
        endcase
        if (i_start) begin
            n_state = (i_dx == '0 && i_dy == '0) ? CS_DONE : CS_RUN;
        end
    end

    always_comb begin
        o_done    = (r_state == CS_DONE);
        o_bearing = r_bearing;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_step    <= '0;
            r_x       <= 28'(ax) <<< 8;
            r_y       <= 28'(ay) <<< 8;
            r_z       <= i_dx[16] ? FINE_180 : 24'sd0;
            r_bearing <= '0;
        end else begin
            case (r_state)
                CS_RUN: begin
                    r_step <= r_step + 1'b1;
                    if (r_y > 0) begin
                        r_x <= r_x + ys;
                        r_y <= r_y - xs;
                        r_z <= r_z + at;
                    end else begin
                        r_x <= r_x - ys;
                        r_y <= r_y + xs;
                        r_z <= r_z - at;
                    end
                end
                CS_NORM: begin
                    if (r_z < 0) begin
                        r_z <= r_z + FINE_360;
                    end else if (r_z >= FINE_360) begin
                        r_z <= r_z - FINE_360;
                    end
                end
                CS_ROUND: begin
                    r_bearing <= (rnd >= {1'b0, FULL_TURN}) ?
                                 15'(rnd - {1'b0, FULL_TURN}) : rnd[14:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== src/rotate_then_drive_waypoint_controller.sv =====
// ----------------------------------------------------------------------------
// rotate_then_drive_waypoint_controller: go-to-goal velocity controller
// Rotate in place toward the goal bearing, hold, then drive by distance band.
// ----------------------------------------------------------------------------
// One word in gives one command word out. From acceptance to a loaded result,
// the iterative CORDIC bearing unit does one micro-rotation a cycle, then a
// wrap step and a round step, then the sequencer sees the bearing done and
// runs the evaluation step. The shared 17x17 multiplier squares dx, dy and the
// arrival radius alongside the CORDIC. When the goal sits on the robot the
// CORDIC is skipped. The input stalls from acceptance until the result is
// loaded, so the block takes no new word before it is through with the last;
// a stalled output holds the evaluation until the output register is free. A
// finished word waits in the output register without blocking the next
// acceptance. Configuration is an APB-style port, registers at 4*index.
`default_nettype none

module rotate_then_drive_waypoint_controller
    import rtdwc_pkg::*;
#(
    parameter int CORDIC_STEPS = RTDWC_CORDIC_STEPS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_word    i_in_word,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_word        o_out_word,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // configuration
    logic [15:0] r_hold_ticks, r_arrive_dist;
    logic [14:0] r_align_tol, r_coarse_band, r_fine_band, r_dev_limit;

    // controller state carried from tick to tick
    logic [1:0]  r_phase, r_turn_sign;
    logic [15:0] r_hold_left;

    // sequencer
    t_state      r_state, n_state;
    logic [1:0]  r_mcnt;
    t_in_word    r_word;
    logic signed [16:0] r_dx, r_dy;
    logic [31:0] r_sqx, r_sqy, r_lim2;

    logic        r_out_valid;
    t_out_word   r_out_word;

    logic        in_acc, out_free, cor_done;
    logic [14:0] bearing;
    logic signed [16:0] dx_in, dy_in, mul_op;
    logic signed [33:0] mul_p;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign dx_in    = $signed({1'b0, i_in_word.goal_x}) - $signed({1'b0, i_in_word.pos_x});
    assign dy_in    = $signed({1'b0, i_in_word.goal_y}) - $signed({1'b0, i_in_word.pos_y});

    rtdwc_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (in_acc),
        .i_dx      (dx_in),
        .i_dy      (dy_in),
        .o_done    (cor_done),
        .o_bearing (bearing)
    );

    // shared multiplier: squares dx, dy, then the arrival radius
    always_comb begin
        case (r_mcnt)
            2'd0:    mul_op = r_dx;
            2'd1:    mul_op = r_dy;
            default: mul_op = $signed({1'b0, r_arrive_dist});
        endcase
        mul_p = mul_op * mul_op;
    end

    // ---------------- tick evaluation ----------------
    logic [14:0] th, aerr;
    logic signed [16:0] err0, err;
    logic [32:0] d2;
    logic        close;
    logic [1:0]  ev_phase, ev_turn;
    logic [15:0] ev_hold;
    logic [3:0]  ev_lin;
    logic signed [7:0] ev_ang, rate;
    logic        ev_arr;

    always_comb begin
        th   = (r_word.heading >= FULL_TURN) ? 15'(r_word.heading - FULL_TURN)
                                             : r_word.heading;
        err0 = $signed({2'b0, bearing}) - $signed({2'b0, th});
        err  = err0;
        if (err0 > $signed({2'b0, HALF_TURN})) begin
            err = err0 - $signed({2'b0, FULL_TURN});
        end
        if (err0 <= -$signed({2'b0, HALF_TURN})) begin
            err = err0 + $signed({2'b0, FULL_TURN});
        end
        aerr  = err[16] ? 15'(-err) : err[14:0];
        d2    = {1'b0, r_sqx} + {1'b0, r_sqy};
        close = d2 <= {1'b0, r_lim2};

        ev_phase = r_word.new_goal ? PH_ROTATE : r_phase;
        ev_turn  = r_turn_sign;
        ev_hold  = r_hold_left;
        ev_lin   = 4'd0;
        ev_ang   = 8'sd0;
        ev_arr   = 1'b0;
        rate     = 8'sd3;

        case (ev_phase)
            PH_HOLD: begin
                if (r_hold_left != '0) begin
                    ev_hold = r_hold_left - 1'b1;
                end else begin
                    ev_phase = PH_DRIVE;
                end
            end
            PH_ROTATE: begin
                // exactly zero or half a turn keeps the old direction
                if (err > 0 && err < $signed({2'b0, HALF_TURN})) begin
                    ev_turn = TURN_POS;
                end else if (err < 0) begin
                    ev_turn = TURN_NEG;
                end
                if (aerr <= r_align_tol || close) begin
                    ev_hold  = r_hold_ticks;
                    ev_phase = PH_HOLD;
                end else begin
                    if (aerr > r_coarse_band) begin
                        rate = 8'sd100;
                    end else if (aerr > r_fine_band) begin
                        rate = 8'sd20;
                    end
                    case (ev_turn)
                        TURN_POS: ev_ang = rate;
                        TURN_NEG: ev_ang = -rate;
                        default:  ev_ang = 8'sd0;
                    endcase
                end
            end
            default: begin
            end
        endcase

        if (ev_phase == PH_DRIVE) begin
            if (close) begin
                ev_arr   = 1'b1;
                ev_phase = PH_IDLE;
            end else if (aerr > r_dev_limit) begin
                ev_phase = PH_ROTATE;
            end else if (d2 > BAND_FAST_SQ) begin
                ev_lin = 4'd15;
            end else if (d2 > BAND_MID_SQ) begin
                ev_lin = 4'd6;
            end else if (d2 > BAND_SLOW_SQ) begin
                ev_lin = 4'd4;
            end else begin
                ev_lin = 4'd2;
            end
        end
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (in_acc) n_state = ST_MUL;
            ST_MUL:  if (r_mcnt == 2'd2) n_state = ST_WAIT;
            ST_WAIT: if (cor_done) n_state = ST_EVAL;
            ST_EVAL: if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall  = (r_state != ST_IDLE);
        o_out_valid = r_out_valid;
        o_out_word  = r_out_word;
        pready      = 1'b1;
        case (paddr[4:2])
            REG_HOLD_TICKS:  prdata = {16'd0, r_hold_ticks};
            REG_ARRIVE_DIST: prdata = {16'd0, r_arrive_dist};
            REG_ALIGN_TOL:   prdata = {17'd0, r_align_tol};
            REG_COARSE_BAND: prdata = {17'd0, r_coarse_band};
            REG_FINE_BAND:   prdata = {17'd0, r_fine_band};
            REG_DEV_LIMIT:   prdata = {17'd0, r_dev_limit};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_mcnt        <= '0;
            r_out_valid   <= 1'b0;
            r_phase       <= PH_IDLE;
            r_turn_sign   <= TURN_NONE;
            r_hold_left   <= '0;
            r_hold_ticks  <= 16'd30000;
            r_arrive_dist <= 16'd102;
            r_align_tol   <= 15'd13;
            r_coarse_band <= 15'd3200;
            r_fine_band   <= 15'd320;
            r_dev_limit   <= 15'd640;
        end else begin
            r_state <= n_state;
            if (r_state == ST_MUL) begin
                r_mcnt <= r_mcnt + 1'b1;
            end else begin
                r_mcnt <= '0;
            end
            // commit the tick and load the result
            if (r_state == ST_EVAL && out_free) begin
                r_out_valid <= 1'b1;
                r_phase     <= ev_phase;
                r_turn_sign <= ev_turn;
                r_hold_left <= ev_hold;
            end else if (r_out_valid && !i_out_stall) begin
                // drop the shown word once taken
                r_out_valid <= 1'b0;
            end
            if (psel && penable && pwrite) begin
                case (paddr[4:2])
                    REG_HOLD_TICKS:  r_hold_ticks  <= pwdata[15:0];
                    REG_ARRIVE_DIST: r_arrive_dist <= pwdata[15:0];
                    REG_ALIGN_TOL:   r_align_tol   <= pwdata[14:0];
                    REG_COARSE_BAND: r_coarse_band <= pwdata[14:0];
                    REG_FINE_BAND:   r_fine_band   <= pwdata[14:0];
                    REG_DEV_LIMIT:   r_dev_limit   <= pwdata[14:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_word <= i_in_word;
            r_dx   <= dx_in;
            r_dy   <= dy_in;
        end
        if (r_state == ST_MUL) begin
            case (r_mcnt)
                2'd0:    r_sqx  <= mul_p[31:0];
                2'd1:    r_sqy  <= mul_p[31:0];
                default: r_lim2 <= mul_p[31:0];
            endcase
        end
        if (r_state == ST_EVAL && out_free) begin
            r_out_word.linear_cmd  <= ev_lin;
            r_out_word.angular_cmd <= ev_ang;
            r_out_word.phase_out   <= ev_phase;
            r_out_word.arrived     <= ev_arr;
        end
    end

endmodule

`default_nettype wire

// ===== src/rtdwc_checker.sv =====
// ----------------------------------------------------------------------------
// rtdwc_checker: port-level checks of the waypoint controller
// Watches handshakes and command words; attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module rtdwc_checker
    import rtdwc_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_stall,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_word o_out_word
);

    // a shown word holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("output word dropped or changed under stall");

    // an accepted word keeps the input stalled while it is worked on
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted twice in a row");

    // arrival ends the run with a zero command
    a_arrive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.arrived |->
        o_out_word.phase_out == PH_IDLE && o_out_word.linear_cmd == 4'd0 &&
        o_out_word.angular_cmd == 8'sd0)
        else $error("arrival word with nonzero command");

    // only the drive phase moves forward, and it never turns
    a_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.linear_cmd != 4'd0 |->
        o_out_word.phase_out == PH_DRIVE && o_out_word.angular_cmd == 8'sd0)
        else $error("forward speed outside drive phase");

endmodule

bind rotate_then_drive_waypoint_controller rtdwc_checker u_rtdwc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

`default_nettype wire
